// ===== hw/rtl/pfc_ingress_buffer_admission_unit_assert.svh =====
// ----------------------------------------------------------------------------
// PFC ingress admission: assertion macros
// Immediate (same-cycle) and next-cycle implication checks on i_clk,
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PFC_INGRESS_BUFFER_ADMISSION_UNIT_ASSERT_SVH
`define PFC_INGRESS_BUFFER_ADMISSION_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PFCBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PFCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pfcba_pkg.sv =====
// ----------------------------------------------------------------------------
// PFC ingress admission package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package pfcba_pkg;

    // default geometry
    localparam int PORTS_DEF  = 64;
    localparam int QUEUES_DEF = 8;

    // config register widths
    localparam int BUF_W     = 27;
    localparam int RSV_W     = 21;
    localparam int OFS_W     = 21;
    localparam int HDR_W     = 23;
    localparam int ALPHA_W   = 5;
    localparam int ACT_W     = 6;
    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 3;

    // config reset values
    localparam logic [BUF_W-1:0] BUF_RST = BUF_W'(12 * 1024 * 1024);
    localparam logic [RSV_W-1:0] RSV_RST = RSV_W'(4 * 1024);
    localparam logic [OFS_W-1:0] OFS_RST = OFS_W'(3 * 1024);

    // input item fields
    localparam int PORT_W  = 6;
    localparam int QUEUE_W = 3;
    localparam int BYTES_W = 16;
    localparam int PORT_LSB  = 0;
    localparam int QUEUE_LSB = PORT_LSB + PORT_W;
    localparam int BYTES_LSB = QUEUE_LSB + QUEUE_W;

    // arithmetic widths
    localparam int CNT_W  = 32;   // byte counters
    localparam int BASE_W = 31;   // buffer minus total headroom and reserve, signed
    localparam int FREE_W = 34;   // base minus shared pool, signed
    localparam int TH_W   = 27;   // threshold

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER     = 3'd0,
        CFG_RESERVE    = 3'd1,
        CFG_RESUME_OFS = 3'd2,
        CFG_HEADROOM   = 3'd3,
        CFG_ALPHA      = 3'd4,
        CFG_ACTIVE     = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        MODE_ARRIVAL   = 1'b0,
        MODE_DEPARTURE = 1'b1
    } t_mode;

    // per-queue state word
    typedef struct packed {
        logic             paused;
        logic [CNT_W-1:0] hdr_used;
        logic [CNT_W-1:0] ing_bytes;
    } t_qentry;

    // config as seen by the decision logic
    typedef struct packed {
        logic [RSV_W-1:0]   reserve;
        logic [OFS_W-1:0]   resume_ofs;
        logic [HDR_W-1:0]   headroom;
        logic [ALPHA_W-1:0] alpha;
        logic [BASE_W-1:0]  base;      // two's complement
    } t_cfg;

    typedef struct packed {
        logic            dropped;
        logic            pause;
        logic            resume;
        logic [TH_W-1:0] threshold;
    } t_admit_res;

endpackage

// ===== hw/rtl/pfcba_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// PFC ingress admission: configuration registers
// Write-only register file plus the registered fixed part of the threshold,
// buffer - active_ports * (headroom + reserve).
// ----------------------------------------------------------------------------
module pfcba_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [pfcba_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [pfcba_pkg::CFG_W-1:0]     i_wdata,
    output pfcba_pkg::t_cfg                 o_cfg
);
    import pfcba_pkg::*;

    localparam int SUM_W  = HDR_W + 1;
    localparam int PROD_W = ACT_W + SUM_W;

    logic [BUF_W-1:0]   r_buffer;
    logic [RSV_W-1:0]   r_reserve;
    logic [OFS_W-1:0]   r_resume_ofs;
    logic [HDR_W-1:0]   r_headroom;
    logic [ALPHA_W-1:0] r_alpha;
    logic [ACT_W-1:0]   r_active;
    logic [BASE_W-1:0]  r_base;

    logic [SUM_W-1:0]   per_port;
    logic [PROD_W-1:0]  all_ports;
    logic [BASE_W-1:0]  n_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer     <= BUF_RST;
            r_reserve    <= RSV_RST;
            r_resume_ofs <= OFS_RST;
            r_headroom   <= '0;
            r_alpha      <= '0;
            r_active     <= '0;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_idx))
                CFG_BUFFER:     r_buffer     <= i_wdata[BUF_W-1:0];
                CFG_RESERVE:    r_reserve    <= i_wdata[RSV_W-1:0];
                CFG_RESUME_OFS: r_resume_ofs <= i_wdata[OFS_W-1:0];
                CFG_HEADROOM:   r_headroom   <= i_wdata[HDR_W-1:0];
                CFG_ALPHA:      r_alpha      <= i_wdata[ALPHA_W-1:0];
                CFG_ACTIVE:     r_active     <= i_wdata[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // one multiply, registered
    assign per_port  = {1'b0, r_headroom} + {{(SUM_W-RSV_W){1'b0}}, r_reserve};
    assign all_ports = {{SUM_W{1'b0}}, r_active} * {{ACT_W{1'b0}}, per_port};
    assign n_base    = {{(BASE_W-BUF_W){1'b0}}, r_buffer}
                     - {{(BASE_W-PROD_W){1'b0}}, all_ports};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= {{(BASE_W-BUF_W){1'b0}}, BUF_RST};
        end else begin
            r_base <= n_base;
        end
    end

    assign o_cfg = '{reserve:    r_reserve,
                     resume_ofs: r_resume_ofs,
                     headroom:   r_headroom,
                     alpha:      r_alpha,
                     base:       r_base};

endmodule

// ===== hw/rtl/pfcba_qstate_ram.sv =====
// ----------------------------------------------------------------------------
// PFC ingress admission: per-queue state memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfcba_qstate_ram #(
    parameter  int DEPTH  = pfcba_pkg::PORTS_DEF * pfcba_pkg::QUEUES_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  pfcba_pkg::t_qentry i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output pfcba_pkg::t_qentry o_rd_data
);
    import pfcba_pkg::*;

    t_qentry r_mem [DEPTH];
    t_qentry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/pfcba_admit_logic.sv =====
// ----------------------------------------------------------------------------
// PFC ingress admission: decision logic
// Arrival/departure accounting for one queue, pause/resume decision and
// the dynamic threshold after the event. Purely combinational.
// ----------------------------------------------------------------------------
module pfcba_admit_logic (
    input  pfcba_pkg::t_cfg                 i_cfg,
    input  logic                            i_in_range,
    input  logic                            i_mode,
    input  logic [pfcba_pkg::BYTES_W-1:0]   i_bytes,
    input  pfcba_pkg::t_qentry              i_entry,
    input  logic [pfcba_pkg::CNT_W-1:0]     i_shared,
    output pfcba_pkg::t_qentry              o_entry,
    output logic [pfcba_pkg::CNT_W-1:0]     o_shared,
    output pfcba_pkg::t_admit_res           o_res
);
    import pfcba_pkg::*;

    localparam int XW    = CNT_W + 1;      // counter plus carry
    localparam int PAD_B = CNT_W - BYTES_W;

    function automatic logic [TH_W-1:0] f_thresh(
        input logic [BASE_W-1:0]  base,
        input logic [CNT_W-1:0]   shared,
        input logic [ALPHA_W-1:0] alpha
    );
        logic [FREE_W-1:0] free;
        logic [TH_W-1:0]   th;
        free = {{(FREE_W-BASE_W){base[BASE_W-1]}}, base}
             - {{(FREE_W-CNT_W){1'b0}}, shared};
        // non-negative free never exceeds the buffer size
        th = free[TH_W-1:0] >> alpha;
        return free[FREE_W-1] ? '0 : th;
    endfunction

    function automatic logic [CNT_W-1:0] f_shared_of(
        input logic [CNT_W-1:0] ing,
        input logic [RSV_W-1:0] reserve
    );
        logic [CNT_W-1:0] rsv;
        rsv = {{(CNT_W-RSV_W){1'b0}}, reserve};
        return (ing > rsv) ? (ing - rsv) : '0;
    endfunction

    function automatic logic [CNT_W-1:0] f_sat(input logic [XW-1:0] v);
        return v[XW-1] ? '1 : v[CNT_W-1:0];
    endfunction

    logic              arrival;
    logic [CNT_W-1:0]  su;
    logic [TH_W-1:0]   th1;
    logic [TH_W-1:0]   th2;
    logic [XW-1:0]     bytes_x;
    logic [XW-1:0]     rsv_x;
    logic [XW-1:0]     th1_x;
    logic [XW-1:0]     sum_hdr;
    logic [XW-1:0]     sum_sh;
    logic [XW-1:0]     nb;
    logic [XW-1:0]     nb_sh;
    logic [XW-1:0]     add;
    logic              over_hdr;
    logic              over_sh;
    logic [BYTES_W-1:0] from_hdr;
    logic [BYTES_W-1:0] rest;
    logic [BYTES_W-1:0] from_sh;
    logic [CNT_W-1:0]  rest_x;
    logic [CNT_W-1:0]  from_sh_x;

    logic              dropped;
    logic              pause;
    logic              resume;
    logic              n_paused;
    logic [CNT_W-1:0]  n_hdr;
    logic [CNT_W-1:0]  n_ing;
    logic [CNT_W-1:0]  n_shared;
    logic [CNT_W-1:0]  nsu;
    logic [CNT_W-1:0]  th2_x;
    logic [XW-1:0]     nsu_ofs;

    assign arrival = (t_mode'(i_mode) == MODE_ARRIVAL);
    assign su      = f_shared_of(i_entry.ing_bytes, i_cfg.reserve);
    assign th1     = f_thresh(i_cfg.base, i_shared, i_cfg.alpha);

    assign bytes_x = {{(XW-BYTES_W){1'b0}}, i_bytes};
    assign rsv_x   = {{(XW-RSV_W){1'b0}}, i_cfg.reserve};
    assign th1_x   = {{(XW-TH_W){1'b0}}, th1};

    // arrival arithmetic
    assign sum_hdr  = {1'b0, i_entry.hdr_used} + bytes_x;
    assign sum_sh   = {1'b0, su} + bytes_x;
    assign over_hdr = sum_hdr > {{(XW-HDR_W){1'b0}}, i_cfg.headroom};
    assign over_sh  = sum_sh > th1_x;
    assign nb       = {1'b0, i_entry.ing_bytes} + bytes_x;
    assign nb_sh    = nb - rsv_x;
    assign add      = (nb_sh < bytes_x) ? nb_sh : bytes_x;

    // departure arithmetic: headroom first, then reserve/shared
    assign from_hdr  = (i_entry.hdr_used < {{PAD_B{1'b0}}, i_bytes})
                     ? i_entry.hdr_used[BYTES_W-1:0] : i_bytes;
    assign rest      = i_bytes - from_hdr;
    assign rest_x    = {{PAD_B{1'b0}}, rest};
    assign from_sh   = (rest_x < su) ? rest : su[BYTES_W-1:0];
    assign from_sh_x = {{PAD_B{1'b0}}, from_sh};

    always_comb begin
        n_ing    = i_entry.ing_bytes;
        n_hdr    = i_entry.hdr_used;
        n_shared = i_shared;
        dropped  = 1'b0;
        if (!i_in_range) begin
            dropped = arrival;
        end else if (arrival) begin
            if (over_hdr && over_sh) begin
                dropped = 1'b1;
            end else if (nb <= rsv_x) begin
                n_ing = f_sat(nb);
            end else if (nb_sh > th1_x) begin
                n_hdr = f_sat(sum_hdr);
            end else begin
                n_ing    = f_sat(nb);
                n_shared = f_sat({1'b0, i_shared} + add);
            end
        end else begin
            n_hdr    = i_entry.hdr_used - {{PAD_B{1'b0}}, from_hdr};
            n_ing    = (i_entry.ing_bytes > rest_x) ? (i_entry.ing_bytes - rest_x) : '0;
            n_shared = (i_shared > from_sh_x) ? (i_shared - from_sh_x) : '0;
        end
    end

    // threshold after the shared pool update
    assign th2     = f_thresh(i_cfg.base, n_shared, i_cfg.alpha);
    assign th2_x   = {{(CNT_W-TH_W){1'b0}}, th2};
    assign nsu     = f_shared_of(n_ing, i_cfg.reserve);
    assign nsu_ofs = {1'b0, nsu} + {{(XW-OFS_W){1'b0}}, i_cfg.resume_ofs};

    always_comb begin
        pause  = 1'b0;
        resume = 1'b0;
        if (i_in_range && arrival && !dropped && !i_entry.paused) begin
            pause = (n_hdr != '0) || (nsu >= th2_x);
        end
        if (i_in_range && !arrival && i_entry.paused && (n_hdr == '0)) begin
            resume = (nsu == '0) || (nsu_ofs <= {1'b0, th2_x});
        end
    end

    assign n_paused = i_entry.paused ? !resume : pause;

    assign o_entry  = '{paused: n_paused, hdr_used: n_hdr, ing_bytes: n_ing};
    assign o_shared = n_shared;
    assign o_res    = '{dropped: dropped, pause: pause, resume: resume, threshold: th2};

endmodule

// ===== hw/rtl/pfc_ingress_buffer_admission_unit.sv =====
// ----------------------------------------------------------------------------
// PFC ingress buffer admission unit
// Per-queue ingress accounting with a dynamic shared-buffer threshold,
// drop decision and pause/resume requests for priority flow control.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                   | beat contents
//  ----------+-----+-----------------------------+------------------------------
//  s_axis    | in  | tvalid/tready               | tuser: mode; tdata: port,
//            |     |                             |   queue, packet_bytes
//  m_axis    | out | tvalid/tready               | tdata: dropped, send_pause,
//            |     |                             |   send_resume, threshold_now
//  cfg       | in  | i_cfg_wr_en, no wait        | register index, write data
//
//  Throughput: one beat per cycle while the output is not stalled. Each beat
//  goes through a registered state-memory read, then one decision stage that
//  writes back and loads the output register.
//  Back-to-back events on the same queue are covered by a one-entry bypass
//  of the last write-back.
//  Reset: synchronous, active low. After reset a clearing pass zeroes all
//  PORTS*QUEUES entries of the state memory (512 by default), one entry per
//  cycle; s_axis tready is low during it. Config writes are taken at any time.
//  Stalls: while the output holds an unaccepted beat the pipeline freezes
//  and s_axis tready drops.
// ----------------------------------------------------------------------------
module pfc_ingress_buffer_admission_unit #(
    parameter int PORTS  = pfcba_pkg::PORTS_DEF,
    parameter int QUEUES = pfcba_pkg::QUEUES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [pfcba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfcba_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input events
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [5:0] port, [8:6] queue, [24:9] packet_bytes, [31:25] zero
    input  logic [pfcba_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] mode
    input  logic [pfcba_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // results
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] dropped, [1] send_pause, [2] send_resume, [29:3] threshold_now,
    // [31:30] zero
    output logic [pfcba_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import pfcba_pkg::*;

    localparam int NQ    = PORTS * QUEUES;
    localparam int IDX_W = $clog2(NQ);
    localparam int RES_W = 3 + TH_W;

    // ---------------- configuration ----------------
    t_cfg cfg;

    pfcba_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // ---------------- input decode ----------------
    logic [PORT_W-1:0]  in_port;
    logic [QUEUE_W-1:0] in_queue;
    logic [BYTES_W-1:0] in_bytes;
    logic               in_range;
    logic [IDX_W-1:0]   in_idx;
    logic               advance;
    logic               s_accept;

    assign in_port  = i_s_axis_tdata[PORT_LSB  +: PORT_W];
    assign in_queue = i_s_axis_tdata[QUEUE_LSB +: QUEUE_W];
    assign in_bytes = i_s_axis_tdata[BYTES_LSB +: BYTES_W];
    assign in_range = (int'(in_port) < PORTS) && (int'(in_queue) < QUEUES);
    assign in_idx   = IDX_W'(int'(in_port) * QUEUES + int'(in_queue));

    // ---------------- control ----------------
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_out_valid;

    // whole pipeline moves when the output register is free or drained
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_clr_busy && advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(NQ - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: state read in flight ----------------
    logic               r_s1_valid;
    logic               r_s1_mode;
    logic               r_s1_in_range;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [BYTES_W-1:0] r_s1_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_mode     <= i_s_axis_tuser[0];
            r_s1_in_range <= in_range;
            r_s1_idx      <= in_idx;
            r_s1_bytes    <= in_bytes;
        end
    end

    // ---------------- state memory ----------------
    t_qentry          rd_entry;
    t_qentry          upd_entry;
    t_qentry          cur_entry;
    t_qentry          wr_entry;
    logic             wb_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // write-back only for a real queue; out-of-range events touch nothing
    assign wb_en   = advance && r_s1_valid && r_s1_in_range;
    assign wr_en   = r_clr_busy || wb_en;
    assign wr_addr = r_clr_busy ? r_clr_addr : r_s1_idx;
    assign wr_entry = r_clr_busy ? t_qentry'('0) : upd_entry;

    pfcba_qstate_ram #(
        .DEPTH (NQ)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (s_accept),
        .i_rd_addr (in_idx),
        .o_rd_data (rd_entry)
    );

    // bypass: the write-back at the edge a new event was read is not yet
    // visible in its read data
    logic             r_byp_valid;
    logic [IDX_W-1:0] r_byp_idx;
    t_qentry          r_byp_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (wb_en) begin
            r_byp_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            r_byp_idx   <= r_s1_idx;
            r_byp_entry <= upd_entry;
        end
    end

    assign cur_entry = (r_byp_valid && (r_byp_idx == r_s1_idx)) ? r_byp_entry : rd_entry;

    // ---------------- decision stage ----------------
    logic [CNT_W-1:0] r_shared;
    logic [CNT_W-1:0] n_shared;
    t_admit_res       res;

    pfcba_admit_logic u_admit (
        .i_cfg      (cfg),
        .i_in_range (r_s1_in_range),
        .i_mode     (r_s1_mode),
        .i_bytes    (r_s1_bytes),
        .i_entry    (cur_entry),
        .i_shared   (r_shared),
        .o_entry    (upd_entry),
        .o_shared   (n_shared),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shared <= '0;
        end else if (advance && r_s1_valid) begin
            r_shared <= n_shared;
        end
    end

    // ---------------- output register ----------------
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] n_out_data;

    assign n_out_data = {{(M_TDATA_W-RES_W){1'b0}},
                         res.threshold, res.resume, res.pause, res.dropped};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/pfcba_port_checker.sv =====
// ----------------------------------------------------------------------------
// PFC ingress admission: port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "pfc_ingress_buffer_admission_unit_assert.svh"

module pfcba_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [pfcba_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import pfcba_pkg::*;

    // a stalled result beat holds
    `PFCBA_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat changed while stalled")

    // drop, pause and resume are mutually exclusive
    `PFCBA_ASSERT_NOW(a_flags_excl, o_m_axis_tvalid, $countones(o_m_axis_tdata[2:0]) <= 1, "more than one of dropped/pause/resume set")

    // a result rises only after an accepted input beat passed stage 1, never from nothing
    `PFCBA_ASSERT_NOW(a_out_from_in, $rose(o_m_axis_tvalid), $past(i_s_axis_tvalid && o_s_axis_tready, 2), "result without a matching input beat")

    // the clearing pass blocks input right after reset
    `PFCBA_ASSERT_NOW(a_clear_blocks, $rose(i_rst_n), !o_s_axis_tready, "input ready during state clearing")

endmodule

bind pfc_ingress_buffer_admission_unit pfcba_port_checker u_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/pfc_ingress_buffer_admission_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PFC ingress buffer admission unit testbench
// Drives packet arrival/departure beats into the unit and checks every result
// beat against a cycle-free model of the per-queue accounting: drop decision,
// pause/resume requests and the dynamic shared-buffer threshold. A short
// directed plan, including register writes, runs first. Randomized phases
// follow, each under its own register setting, with bursty stalls on both
// stream sides except in the last phase.
// ----------------------------------------------------------------------------
module pfc_ingress_buffer_admission_unit_tb;
    import pfcba_pkg::*;

    localparam int              NQ          = PORTS_DEF * QUEUES_DEF;
    localparam int              STALL_LIMIT = 4000;  // > clearing pass + stalls
    localparam int              NPHASE      = 8;
    localparam int              PHASE_BEATS = 210;
    localparam int              NHOT        = 4;
    localparam longint unsigned CNT_MAX     = 64'hFFFF_FFFF;

    // one row of the directed plan: a register write or an event
    typedef struct {
        bit               is_reg;
        t_cfg_idx         reg_idx;
        int               reg_val;
        t_mode            mode;
        int               port;
        int               qu;
        int               len;
        bit               known;   // result typed in below
        t_admit_res       want;
    } t_plan_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [CFG_W-1:0]     i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    always #1 i_clk = ~i_clk;

    pfc_ingress_buffer_admission_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Accounting model: registers, per-queue counters, shared pool
    // ------------------------------------------------------------------------
    longint unsigned  buf_total, rsv_per_q, resume_ofs, hdr_limit, alpha, act_ports;
    logic [CNT_W-1:0] ing_bytes [NQ];
    logic [CNT_W-1:0] hdr_used  [NQ];
    bit               q_paused  [NQ];
    logic [CNT_W-1:0] pool_used;

    t_admit_res verdicts_due [$];   // results still owed by the unit
    int         errors       = 0;
    int         n_arrivals   = 0;
    int         n_departures = 0;
    int         n_drops      = 0;
    int         n_pauses     = 0;
    int         n_resumes    = 0;
    int         n_settings   = 0;
    bit         calm         = 1'b0;  // no stalls on either side
    int         idle_cycles  = 0;

    function automatic longint unsigned sat_cnt(longint unsigned v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    // bytes above the queue reserve
    function automatic longint unsigned shared_part(longint unsigned ing);
        return (ing > rsv_per_q) ? ing - rsv_per_q : 0;
    endfunction

    // free buffer after total headroom, total reserve and pool, shifted;
    // zero when overcommitted
    function automatic longint unsigned dyn_threshold();
        longint unsigned held;
        held = act_ports * hdr_limit + act_ports * rsv_per_q + longint'(pool_used);
        if (buf_total < held)
            return 0;
        return (buf_total - held) >> alpha;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        case (idx)
            CFG_BUFFER:     buf_total  = v[BUF_W-1:0];
            CFG_RESERVE:    rsv_per_q  = v[RSV_W-1:0];
            CFG_RESUME_OFS: resume_ofs = v[OFS_W-1:0];
            CFG_HEADROOM:   hdr_limit  = v[HDR_W-1:0];
            CFG_ALPHA:      alpha      = v[ALPHA_W-1:0];
            CFG_ACTIVE:     act_ports  = v[ACT_W-1:0];
            default: ;
        endcase
    endfunction

    // applies one packet event to the model and returns its verdict
    function automatic t_admit_res admit_event(t_mode mode, int port, int qu, int len);
        t_admit_res      r;
        int              i;
        longint unsigned ing, hdr, th, nb, add, psz;
        longint unsigned from_hdr, rest, su, from_sh, nsu;
        r   = '0;
        i   = port * QUEUES_DEF + qu;
        ing = ing_bytes[i];
        hdr = hdr_used[i];
        psz = len;
        if (mode == MODE_ARRIVAL) begin
            th = dyn_threshold();
            if (psz + hdr > hdr_limit && psz + shared_part(ing) > th) begin
                r.dropped = 1'b1;
            end else begin
                nb = ing + psz;
                if (nb <= rsv_per_q) begin
                    ing_bytes[i] = CNT_W'(sat_cnt(nb));
                end else if (nb - rsv_per_q > th) begin
                    // over the threshold: goes to headroom
                    hdr_used[i] = CNT_W'(sat_cnt(hdr + psz));
                end else begin
                    add = nb - rsv_per_q;
                    if (add > psz)
                        add = psz;
                    ing_bytes[i] = CNT_W'(sat_cnt(nb));
                    pool_used    = CNT_W'(sat_cnt(longint'(pool_used) + add));
                end
                if (!q_paused[i] && (hdr_used[i] != 0 ||
                        shared_part(ing_bytes[i]) >= dyn_threshold())) begin
                    q_paused[i] = 1'b1;
                    r.pause     = 1'b1;
                end
            end
        end else begin
            // headroom drains first, then reserve and shared bytes
            from_hdr     = (hdr < psz) ? hdr : psz;
            rest         = psz - from_hdr;
            su           = shared_part(ing);
            from_sh      = (rest < su) ? rest : su;
            hdr_used[i]  = CNT_W'(hdr - from_hdr);
            ing_bytes[i] = CNT_W'((ing > rest) ? ing - rest : 0);
            pool_used    = (longint'(pool_used) > from_sh) ? CNT_W'(pool_used - from_sh) : '0;
            if (q_paused[i] && hdr_used[i] == 0) begin
                nsu = shared_part(ing_bytes[i]);
                if (nsu == 0 || nsu + resume_ofs <= dyn_threshold()) begin
                    q_paused[i] = 1'b0;
                    r.resume    = 1'b1;
                end
            end
        end
        r.threshold = TH_W'(dyn_threshold());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Plan rows
    // ------------------------------------------------------------------------
    function automatic t_plan_row blank_row();
        t_plan_row row;
        row.is_reg  = 1'b0;
        row.reg_idx = CFG_BUFFER;
        row.reg_val = 0;
        row.mode    = MODE_ARRIVAL;
        row.port    = 0;
        row.qu      = 0;
        row.len     = 0;
        row.known   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_plan_row ev(t_mode m, int p, int q, int len);
        t_plan_row row;
        row      = blank_row();
        row.mode = m;
        row.port = p;
        row.qu   = q;
        row.len  = len;
        return row;
    endfunction

    function automatic t_plan_row ev_known(t_mode m, int p, int q, int len,
                                           bit d, bit pa, bit re, int th);
        t_plan_row row;
        row                = ev(m, p, q, len);
        row.known          = 1'b1;
        row.want.dropped   = d;
        row.want.pause     = pa;
        row.want.resume    = re;
        row.want.threshold = TH_W'(th);
        return row;
    endfunction

    function automatic t_plan_row reg_step(t_cfg_idx idx, int val);
        t_plan_row row;
        row         = blank_row();
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // register write: only with the unit idle, every owed result back
    task automatic set_reg(t_cfg_idx idx, int val);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);   // pipeline is 2 deep
        i_cfg_wr_en = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = CFG_W'(val);
        apply_reg(idx, CFG_W'(val));
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // one event beat; tvalid stays high after the handshake so the next
    // beat can follow back to back
    task automatic offer_event(t_mode m, int p, int q, int len,
                               bit known, t_admit_res want);
        int         gap;
        t_admit_res verdict;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        // [5:0] port, [8:6] queue, [24:9] packet_bytes
        i_s_axis_tdata  = {7'b0, 16'(len), 3'(q), 6'(p)};
        i_s_axis_tuser  = m;
        do @(posedge i_clk); while (!o_s_axis_tready);
        verdict = admit_event(m, p, q, len);
        verdicts_due.push_back(known ? want : verdict);
        if (m == MODE_ARRIVAL)
            n_arrivals++;
        else
            n_departures++;
    endtask

    // most beats hit a few busy queues so they fill, pause and drain
    task automatic random_event(int hot_port[NHOT], int hot_q[NHOT]);
        t_mode m;
        int    p, q, len, sel, sz;
        if ($urandom_range(0, 99) < 85) begin
            sel = $urandom_range(0, NHOT - 1);
            p   = hot_port[sel];
            q   = hot_q[sel];
            m   = ($urandom_range(0, 99) < 55) ? MODE_ARRIVAL : MODE_DEPARTURE;
        end else begin
            p = $urandom_range(0, PORTS_DEF - 1);
            q = $urandom_range(0, QUEUES_DEF - 1);
            m = t_mode'($urandom_range(0, 1));
        end
        sz  = $urandom_range(0, 9);
        len = (sz < 7) ? $urandom_range(64, 9216) :
              (sz < 9) ? $urandom_range(0, 65535) : $urandom_range(0, 63);
        offer_event(m, p, q, len, 1'b0, '0);
    endtask

    // result side backpressure in bursts
    initial begin : sink_ready
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_m_axis_tready = 1'b0;
                hold--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold            = $urandom_range(1, 4) - 1;
                i_m_axis_tready = 1'b0;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every beat against the oldest owed verdict
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_admit_res      want;
        logic [TH_W-1:0] got_th;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            // [0] dropped, [1] send_pause, [2] send_resume, [29:3] threshold_now
            got_th = o_m_axis_tdata[3 +: TH_W];
            if (verdicts_due.size() == 0) begin
                $error("result beat with no event outstanding: tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                n_drops   += want.dropped;
                n_pauses  += want.pause;
                n_resumes += want.resume;
                if (o_m_axis_tdata[0] !== want.dropped) begin
                    $error("dropped: expected %0d, got %0d", want.dropped, o_m_axis_tdata[0]);
                    errors++;
                end
                if (o_m_axis_tdata[1] !== want.pause) begin
                    $error("send_pause: expected %0d, got %0d", want.pause, o_m_axis_tdata[1]);
                    errors++;
                end
                if (o_m_axis_tdata[2] !== want.resume) begin
                    $error("send_resume: expected %0d, got %0d", want.resume,
                           o_m_axis_tdata[2]);
                    errors++;
                end
                if (got_th !== want.threshold) begin
                    $error("threshold_now: expected %0d, got %0d", want.threshold, got_th);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without a handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("pfc_ingress_buffer_admission_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_plan_row plan [$];
        int        hot_port [NHOT];
        int        hot_q    [NHOT];

        buf_total  = BUF_RST;
        rsv_per_q  = RSV_RST;
        resume_ofs = OFS_RST;
        hdr_limit  = 0;
        alpha      = 0;
        act_ports  = 0;
        pool_used  = '0;
        for (int i = 0; i < NQ; i++) begin
            ing_bytes[i] = '0;
            hdr_used[i]  = '0;
            q_paused[i]  = 1'b0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: full 12 MiB free, no headroom
        plan.push_back(ev_known(MODE_ARRIVAL,    0, 0, 0,     0, 0, 0, 12582912));
        plan.push_back(ev_known(MODE_DEPARTURE,  0, 0, 100,   0, 0, 0, 12582912)); // empty q
        plan.push_back(ev_known(MODE_ARRIVAL,   63, 7, 4096,  0, 0, 0, 12582912)); // fills rsv
        plan.push_back(ev_known(MODE_ARRIVAL,   63, 7, 65535, 0, 0, 0, 12517377)); // all shared
        plan.push_back(ev(MODE_DEPARTURE, 63, 7, 65535));
        plan.push_back(ev(MODE_DEPARTURE, 63, 7, 65535));     // more than held
        // widest shift: threshold zero, no headroom -> drop
        plan.push_back(reg_step(CFG_ALPHA, 31));
        plan.push_back(ev_known(MODE_ARRIVAL,    1, 2, 65535, 1, 0, 0, 0));
        // large headroom: absorbed there, queue pauses, then a partial drain
        plan.push_back(reg_step(CFG_HEADROOM, 4194304));
        plan.push_back(ev(MODE_ARRIVAL,    1, 2, 65535));
        plan.push_back(ev(MODE_ARRIVAL,    1, 2, 1000));
        plan.push_back(ev(MODE_DEPARTURE,  1, 2, 65535));
        // overcommitted buffer
        plan.push_back(reg_step(CFG_ACTIVE, 63));
        plan.push_back(reg_step(CFG_BUFFER, 0));
        plan.push_back(ev(MODE_ARRIVAL,    2, 0, 100));
        plan.push_back(ev(MODE_DEPARTURE,  2, 0, 100));
        // large buffer and reserve, large resume offset
        plan.push_back(reg_step(CFG_HEADROOM, 0));
        plan.push_back(reg_step(CFG_RESERVE, 1048576));
        plan.push_back(reg_step(CFG_BUFFER, 67108864));
        plan.push_back(reg_step(CFG_ALPHA, 0));
        plan.push_back(reg_step(CFG_RESUME_OFS, 1048576));
        plan.push_back(ev(MODE_ARRIVAL,    5, 3, 65535));
        plan.push_back(ev(MODE_DEPARTURE,  5, 3, 30000));
        plan.push_back(ev(MODE_ARRIVAL,    9, 4, 9000));
        plan.push_back(ev(MODE_DEPARTURE,  9, 4, 9000));

        foreach (plan[k]) begin
            if (plan[k].is_reg)
                set_reg(plan[k].reg_idx, plan[k].reg_val);
            else
                offer_event(plan[k].mode, plan[k].port, plan[k].qu, plan[k].len,
                            plan[k].known, plan[k].want);
        end

        // random phases: large settings, all-zero, then settings where the
        // threshold sits near typical queue depths
        for (int ph = 0; ph < NPHASE; ph++) begin
            if (ph == 0) begin
                set_reg(CFG_BUFFER, 67108864);
                set_reg(CFG_RESERVE, 1048576);
                set_reg(CFG_RESUME_OFS, 1048576);
                set_reg(CFG_HEADROOM, 4194304);
                set_reg(CFG_ALPHA, 31);
                set_reg(CFG_ACTIVE, 63);
            end else if (ph == 1) begin
                set_reg(CFG_BUFFER, 0);
                set_reg(CFG_RESERVE, 0);
                set_reg(CFG_RESUME_OFS, 0);
                set_reg(CFG_HEADROOM, 0);
                set_reg(CFG_ALPHA, 0);
                set_reg(CFG_ACTIVE, 0);
            end else begin
                set_reg(CFG_BUFFER, $urandom_range(60000, 1500000));
                set_reg(CFG_RESERVE, $urandom_range(0, 12000));
                set_reg(CFG_RESUME_OFS, $urandom_range(0, 6000));
                set_reg(CFG_HEADROOM, $urandom_range(0, 40000));
                set_reg(CFG_ALPHA, $urandom_range(0, 3));
                set_reg(CFG_ACTIVE, $urandom_range(0, 12));
            end
            n_settings++;
            for (int h = 0; h < NHOT; h++) begin
                hot_port[h] = $urandom_range(0, PORTS_DEF - 1);
                hot_q[h]    = $urandom_range(0, QUEUES_DEF - 1);
            end
            calm = (ph == NPHASE - 1);
            repeat (PHASE_BEATS) random_event(hot_port, hot_q);
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d arrivals and %0d departures over %0d random settings",
                 n_arrivals, n_departures, n_settings);
        $display("results seen: %0d drops, %0d pauses, %0d resumes",
                 n_drops, n_pauses, n_resumes);
        if (errors == 0)
            $display("pfc_ingress_buffer_admission_unit verification clean");
        else
            $display("pfc_ingress_buffer_admission_unit verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pfcba_pkg.sv
hw/rtl/pfcba_cfg_regs.sv
hw/rtl/pfcba_qstate_ram.sv
hw/rtl/pfcba_admit_logic.sv
hw/rtl/pfc_ingress_buffer_admission_unit.sv
hw/rtl/pfcba_port_checker.sv
tb/pfc_ingress_buffer_admission_unit_tb.sv
